// ===== rtl/tcce_pkg.sv =====
package tcce_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int CODE_W   = 8;
	localparam int LINES_W  = 5;
	localparam int ATTR_W   = 8;
	localparam int INDEX_W  = 11;
	localparam int VALUE_W  = 16;
	localparam int ROW_W    = 5;
	localparam int COL_W    = 7;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_LINES   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTRIBUTE = 1'd1;

	localparam logic [LINES_W-1:0] SCROLL_LINES_RST   = 5'd1;
	localparam logic [ATTR_W-1:0]  TEXT_ATTRIBUTE_RST = 8'd7;

	localparam logic [CODE_W-1:0] CODE_BELL  = 8'd7;
	localparam logic [CODE_W-1:0] CODE_BS    = 8'd8;
	localparam logic [CODE_W-1:0] CODE_LF    = 8'd10;
	localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;
	localparam logic [CODE_W-1:0] CODE_BLANK = 8'h20;

	typedef struct packed {
		logic               we;
		logic [INDEX_W-1:0] idx;
		logic [VALUE_W-1:0] val;
		logic               scr;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
	} tcce_res_t;

endpackage

// ===== rtl/tcce_cursor.sv =====
module tcce_cursor #(
	parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [tcce_pkg::CODE_W-1:0]  code,
	input  logic [tcce_pkg::LINES_W-1:0] scroll_lines,
	input  logic [tcce_pkg::ATTR_W-1:0]  text_attribute,
	output tcce_pkg::tcce_res_t          res
);
	import tcce_pkg::*;

	localparam int RW  = $clog2(ROWS);
	localparam int CW  = $clog2(COLUMNS);
	localparam int SW  = RW + 1;
	localparam int CIW = CW + 1;
	localparam int XW  = (RW + CW > INDEX_W) ? RW + CW : INDEX_W;
	localparam int RXW = (RW > ROW_W) ? RW : ROW_W;
	localparam int CXW = (CW > COL_W) ? CW : COL_W;

	logic [RW-1:0] row_q, row_n;
	logic [CW-1:0] col_q, col_n;

	logic [SW-1:0]  l_eff;
	logic [SW-1:0]  row_sum;
	logic           lf_scr;
	logic [RW-1:0]  lf_row;
	logic [CIW-1:0] col_inc;
	logic [CW-1:0]  idx_col;
	logic [XW-1:0]  idx_full;
	logic [RXW-1:0] row_ext;
	logic [CXW-1:0] col_ext;

	// saturate the scroll count to the grid height
	always_comb begin
		if (int'(scroll_lines) > ROWS) begin
			l_eff = SW'(ROWS);
		end else begin
			l_eff = SW'(scroll_lines);
		end
		row_sum = SW'(row_q) + l_eff;
		lf_scr  = (row_sum >= SW'(ROWS));
		lf_row  = lf_scr ? row_q : row_sum[RW-1:0];
		col_inc = CIW'(col_q) + CIW'(1);
		idx_col = (code == CODE_BS) ? (col_q - CW'(1)) : col_q;
		idx_full = XW'(row_q) * XW'(COLUMNS) + XW'(idx_col);
	end

	always_comb begin
		row_n   = row_q;
		col_n   = col_q;
		res     = '0;
		case (code)
			CODE_BS: begin
				if (col_q != '0) begin
					col_n   = idx_col;
					res.we  = 1'b1;
					res.idx = idx_full[INDEX_W-1:0];
					res.val = {text_attribute, CODE_BLANK};
				end
			end
			CODE_CR: begin
				col_n = '0;
			end
			CODE_LF: begin
				col_n   = '0;
				row_n   = lf_row;
				res.scr = lf_scr;
			end
			CODE_BELL: begin
			end
			default: begin
				res.we  = 1'b1;
				res.idx = idx_full[INDEX_W-1:0];
				res.val = {text_attribute, code};
				if (col_inc >= CIW'(COLUMNS)) begin
					// wrap: line feed in the same item
					col_n   = '0;
					row_n   = lf_row;
					res.scr = lf_scr;
				end else begin
					col_n = col_inc[CW-1:0];
				end
			end
		endcase
		row_ext = RXW'(row_n);
		col_ext = CXW'(col_n);
		res.row = row_ext[ROW_W-1:0];
		res.col = col_ext[COL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (step) begin
			row_q <= row_n;
			col_q <= col_n;
		end
	end

`ifndef SYNTH
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(row_q) < ROWS)
		else $error("cursor row out of range");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(col_q) < COLUMNS)
		else $error("cursor column out of range");

	a_bell_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && code == CODE_BELL |=> $stable(row_q) && $stable(col_q))
		else $error("bell moved the cursor");

	a_cr_home: assert property (@(posedge clk) disable iff (!arst_n)
		step && code == CODE_CR |=> col_q == '0 && $stable(row_q))
		else $error("carriage return did not home the column");

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.scr |=> $stable(row_q))
		else $error("row moved on a scroll");
`endif

endmodule

// ===== rtl/text_console_cursor_engine.sv =====
// Text console cursor engine. Each character item yields exactly one result:
// the cell write (index and attribute/character value) if any, a scroll flag,
// and the cursor position after the item. An item passes through an input
// register and then a result register, where its result is presented; a
// stall on the output can hold the item in either register. One
// item is accepted every cycle while out_stall stays low; while a finished
// result waits, one more item can still enter the empty input register.
// Registers scroll_lines (index 0) and text_attribute (index 1) are written
// through the cfg port, which is always ready, and should only change while
// no item is in flight.
module text_console_cursor_engine #(
	parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [tcce_pkg::CODE_W-1:0]     char_code,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            write_enable,
	output logic [tcce_pkg::INDEX_W-1:0]    cell_index,
	output logic [tcce_pkg::VALUE_W-1:0]    cell_value,
	output logic                            scroll_enable,
	output logic [tcce_pkg::ROW_W-1:0]      cursor_row,
	output logic [tcce_pkg::COL_W-1:0]      cursor_col,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tcce_pkg::*;

	logic [LINES_W-1:0] scroll_lines_q;
	logic [ATTR_W-1:0]  text_attribute_q;

	logic               valid_s1;
	logic [CODE_W-1:0]  code_s1;
	logic               advance;
	logic               in_take;

	tcce_res_t          res;
	tcce_res_t          res_q;
	logic               out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_lines_q   <= SCROLL_LINES_RST;
			text_attribute_q <= TEXT_ATTRIBUTE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SCROLL_LINES:   scroll_lines_q   <= cfg_data[LINES_W-1:0];
				CFG_TEXT_ATTRIBUTE: text_attribute_q <= cfg_data[ATTR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// advance the input stage whenever the result register is free or drains
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			code_s1 <= char_code;
		end
	end

	tcce_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_cursor (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (valid_s1 && advance),
		.code          (code_s1),
		.scroll_lines  (scroll_lines_q),
		.text_attribute(text_attribute_q),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign write_enable  = res_q.we;
	assign cell_index    = res_q.idx;
	assign cell_value    = res_q.val;
	assign scroll_enable = res_q.scr;
	assign cursor_row    = res_q.row;
	assign cursor_col    = res_q.col;

endmodule

// ===== tb/tb.sv =====
module tb;
	import tcce_pkg::*;

	localparam int COLS        = COLUMNS_DEF;
	localparam int ROWS_N      = ROWS_DEF;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic [CODE_W-1:0]     char_code = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  write_enable;
	logic [INDEX_W-1:0]    cell_index;
	logic [VALUE_W-1:0]    cell_value;
	logic                  scroll_enable;
	logic [ROW_W-1:0]      cursor_row;
	logic [COL_W-1:0]      cursor_col;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// cursor model state and register copies
	int                 cur_row  = 0;
	int                 cur_col  = 0;
	logic [LINES_W-1:0] lines_reg = SCROLL_LINES_RST;
	logic [ATTR_W-1:0]  attr_reg  = TEXT_ATTRIBUTE_RST;

	logic [CODE_W-1:0] char_backlog[$];
	tcce_res_t         cells_expected[$];
	tcce_res_t         seen;
	tcce_res_t         want;

	int          burst_left = 1;
	int          gap_left   = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left  = 0;
	int          mismatches = 0;
	int          cycles     = 0;

	text_console_cursor_engine #(
		.COLUMNS(COLS),
		.ROWS(ROWS_N)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.write_enable(write_enable),
		.cell_index(cell_index),
		.cell_value(cell_value),
		.scroll_enable(scroll_enable),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic feed_line();
		int step;
		logic scrolled;
		step = (lines_reg > ROWS_N) ? ROWS_N : int'(lines_reg);
		scrolled = 1'b0;
		cur_row += step;
		cur_col = 0;
		if (cur_row >= ROWS_N) begin
			scrolled = 1'b1;
			cur_row -= step;
		end
		if (cur_row >= ROWS_N)
			cur_row = ROWS_N - 1;
		return scrolled;
	endfunction

	function automatic tcce_res_t console_step(logic [CODE_W-1:0] code);
		tcce_res_t r;
		r = '0;
		if (code == CODE_BS) begin
			if (cur_col > 0) begin
				cur_col -= 1;
				r.we  = 1'b1;
				r.idx = INDEX_W'(cur_row * COLS + cur_col);
				r.val = {attr_reg, CODE_BLANK};
			end
		end else if (code == CODE_CR) begin
			cur_col = 0;
		end else if (code == CODE_LF) begin
			r.scr = feed_line();
		end else if (code != CODE_BELL) begin
			r.we  = 1'b1;
			r.idx = INDEX_W'(cur_row * COLS + cur_col);
			r.val = {attr_reg, code};
			cur_col += 1;
			if (cur_col >= COLS)
				r.scr = feed_line();
		end
		r.row = ROW_W'(cur_row);
		r.col = COL_W'(cur_col);
		return r;
	endfunction

	function automatic logic [CODE_W-1:0] printable_code();
		logic [CODE_W-1:0] c;
		do
			c = CODE_W'($urandom_range(0, 255));
		while (c == CODE_BS || c == CODE_LF || c == CODE_CR || c == CODE_BELL);
		return c;
	endfunction

	function automatic logic [CODE_W-1:0] random_code();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 10)
			return printable_code();
		else if (pick < 13)
			return CODE_LF;
		else if (pick < 15)
			return CODE_BS;
		else if (pick == 15)
			return CODE_CR;
		else if (pick == 16)
			return CODE_BELL;
		return CODE_W'($urandom_range(0, 255));
	endfunction

	// mostly mixed text, with long printable runs so lines wrap
	task automatic queue_text(input int count);
		int n;
		int run;
		n = 0;
		@(negedge clk);
		while (n < count) begin
			if ($urandom_range(0, 15) == 0) begin
				run = $urandom_range(50, 90);
				repeat (run) char_backlog.push_back(printable_code());
				n += run;
			end else begin
				char_backlog.push_back(random_code());
				n++;
			end
		end
	endtask

	task automatic settle();
		do
			@(posedge clk);
		while (char_backlog.size() != 0 || in_valid || cells_expected.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_SCROLL_LINES)
			lines_reg = data[LINES_W-1:0];
		else
			attr_reg = data;
	endtask

	// driver: bursts of items with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			char_code <= '0;
		end else begin
			if (in_valid && !in_stall)
				cells_expected.push_back(console_step(char_code));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (char_backlog.size() != 0) begin
					in_valid  <= 1'b1;
					char_code <= char_backlog.pop_front();
					if (burst_left <= 1) begin
						burst_left <= ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result, stall on a changing pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = {write_enable, cell_index, cell_value, scroll_enable, cursor_row,
					cursor_col};
				if (cells_expected.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: we=%0b idx=%0d val=%h scr=%0b row=%0d col=%0d",
							seen.we, seen.idx, seen.val, seen.scr, seen.row, seen.col);
					mismatches++;
				end else begin
					want = cells_expected.pop_front();
					if (seen.we !== want.we || seen.idx !== want.idx || seen.val !== want.val ||
						seen.scr !== want.scr || seen.row !== want.row ||
						seen.col !== want.col) begin
						if (mismatches < 10) begin
							$display("mismatch exp: we=%0b idx=%0d val=%h scr=%0b row=%0d col=%0d",
								want.we, want.idx, want.val, want.scr, want.row, want.col);
							$display("         got: we=%0b idx=%0d val=%h scr=%0b row=%0d col=%0d",
								seen.we, seen.idx, seen.val, seen.scr, seen.row, seen.col);
						end
						mismatches++;
					end
				end
			end
			if (mode_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				mode_left  <= $urandom_range(20, 120);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= !out_stall;
			endcase
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("text_console_cursor_engine verification failed");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// defaults: extremes of the code, backspace down to and past the left column
		@(negedge clk);
		char_backlog = {8'h00, 8'hFF, 8'h41, CODE_BS, CODE_BS, CODE_BS, CODE_BS, CODE_BELL,
			8'h80, 8'h7F, CODE_CR, CODE_LF, CODE_BLANK, CODE_LF, CODE_BS};
		settle();

		// full-screen scroll count, upper data bits set
		write_reg(CFG_SCROLL_LINES, 8'hF9);
		write_reg(CFG_TEXT_ATTRIBUTE, 8'hFF);
		@(negedge clk);
		char_backlog = {8'h5A, CODE_LF, CODE_LF, 8'h71, CODE_CR, CODE_BS, CODE_LF};
		settle();
		queue_text(90);
		settle();

		// zero scroll count: line feed only returns the column
		write_reg(CFG_SCROLL_LINES, 8'h00);
		write_reg(CFG_TEXT_ATTRIBUTE, 8'h00);
		@(negedge clk);
		char_backlog = {CODE_LF, 8'h78, CODE_LF};
		settle();
		queue_text(90);
		settle();

		// count above the row total saturates
		write_reg(CFG_SCROLL_LINES, 8'h1F);
		write_reg(CFG_TEXT_ATTRIBUTE, 8'h5A);
		queue_text(90);
		settle();

		write_reg(CFG_SCROLL_LINES, 8'h01);
		write_reg(CFG_TEXT_ATTRIBUTE, 8'h07);
		queue_text(120);
		settle();

		write_reg(CFG_SCROLL_LINES, 8'h03);
		write_reg(CFG_TEXT_ATTRIBUTE, 8'hA5);
		queue_text(90);
		settle();

		write_reg(CFG_SCROLL_LINES, 8'd24);
		write_reg(CFG_TEXT_ATTRIBUTE, 8'h3C);
		queue_text(80);
		settle();

		repeat (2) begin
			write_reg(CFG_SCROLL_LINES, CFG_DATA_W'($urandom_range(0, 255)));
			write_reg(CFG_TEXT_ATTRIBUTE, CFG_DATA_W'($urandom_range(0, 255)));
			queue_text(70);
			settle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && cells_expected.size() == 0)
			$display("text_console_cursor_engine verification clean");
		else
			$display("text_console_cursor_engine verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/tcce_pkg.sv
rtl/tcce_cursor.sv
rtl/text_console_cursor_engine.sv
tb/tb.sv
